FILE: rtl/scat_pkg.sv
// Package of the scancode-set-1 to ASCII translator.
// Holds command codes, scancode constants, the US layout tables and shared structs.
// No dependencies.
package scat_pkg;

  localparam logic [1:0] OP_SCAN  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] SC_PREFIX  = 8'hE0;
  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;
  localparam logic [6:0] SC_CTRL    = 7'h1D;
  localparam logic [6:0] SC_ALT     = 7'h38;
  localparam logic [6:0] SC_CAPS    = 7'h3A;
  localparam logic [6:0] SC_NUM     = 7'h45;
  localparam logic [6:0] SC_SCROLL  = 7'h46;

  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_LOWER_Z = 7'h7A;
  localparam logic [6:0] CTRL_BASE  = 7'h60;

  localparam logic [6:0] PLAIN_MAP [128] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [6:0] SHIFT_MAP [128] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [6:0] wdata;
  } ring_cmd_t;

  typedef struct packed {
    logic [6:0] read_char;
    logic       char_dropped;
    logic       has_input;
  } ring_stat_t;

  typedef struct packed {
    logic       event_valid;
    logic [6:0] event_ascii;
    logic [7:0] event_scancode;
    logic       event_pressed;
    logic [2:0] event_modifiers;
    logic       led_write;
    logic [2:0] led_bits;
    logic [2:0] modifiers_now;
  } key_out_t;

  function automatic logic is_lower(input logic [6:0] c);
    return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
  endfunction

endpackage

FILE: rtl/scat_if.sv
// Channel interfaces of the scancode translator: command, configuration and result.
// Each carries valid, ready and its payload; a beat moves when both are high.
// No dependencies.
interface scat_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] scan_byte;
  modport source (output valid, opcode, scan_byte, input ready);
  modport sink (input valid, opcode, scan_byte, output ready);
endinterface

interface scat_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface scat_res_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [6:0] event_ascii;
  logic [7:0] event_scancode;
  logic       event_pressed;
  logic [2:0] event_modifiers;
  logic       led_write;
  logic [2:0] led_bits;
  logic [6:0] read_char;
  logic       char_dropped;
  logic       has_input;
  logic [2:0] modifiers_now;
  modport source (output valid, event_valid, event_ascii, event_scancode, event_pressed,
                  event_modifiers, led_write, led_bits, read_char, char_dropped,
                  has_input, modifiers_now, input ready);
  modport sink (input valid, event_valid, event_ascii, event_scancode, event_pressed,
                event_modifiers, led_write, led_bits, read_char, char_dropped,
                has_input, modifiers_now, output ready);
endinterface

FILE: rtl/scat_keystate.sv
// Modifier and lock state with the key translation of the scancode translator.
// Depends on scat_pkg.
module scat_keystate (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [1:0]          opcode,
  input  logic [7:0]          scan_byte,
  input  logic                event_enable,
  output scat_pkg::key_out_t  key_out,
  output scat_pkg::ring_cmd_t ring_cmd
);
  import scat_pkg::*;

  logic shift_down, ctrl_down, alt_down, caps_on, num_on, scroll_on;
  logic shift_down_next, ctrl_down_next, alt_down_next;
  logic caps_on_next, num_on_next, scroll_on_next;

  logic       is_scan;
  logic       released;
  logic [6:0] key;
  logic       is_mod_key;
  logic       is_lock_press;
  logic       is_other;
  logic [6:0] base_char;
  logic       shift_sel;
  logic [6:0] shifted_char;
  logic [6:0] key_char;
  logic [2:0] mods_before;

  always_comb begin
    is_scan     = (opcode == OP_SCAN) && (scan_byte != SC_PREFIX);
    released    = scan_byte[7];
    key         = scan_byte[6:0];
    mods_before = {alt_down, ctrl_down, shift_down};
    is_mod_key  = (key == SC_LSHIFT) || (key == SC_RSHIFT) || (key == SC_CTRL) ||
                  (key == SC_ALT);
    is_lock_press = !released && ((key == SC_CAPS) || (key == SC_NUM) ||
                    (key == SC_SCROLL));
    is_other    = is_scan && !is_mod_key && !is_lock_press;

    base_char    = PLAIN_MAP[key];
    shift_sel    = shift_down ^ (caps_on && is_lower(base_char));
    shifted_char = shift_sel ? SHIFT_MAP[key] : base_char;
    if (ctrl_down && is_lower(shifted_char)) begin
      key_char = shifted_char - CTRL_BASE;
    end else begin
      key_char = shifted_char;
    end

    shift_down_next = shift_down;
    ctrl_down_next  = ctrl_down;
    alt_down_next   = alt_down;
    caps_on_next    = caps_on;
    num_on_next     = num_on;
    scroll_on_next  = scroll_on;
    if (is_scan) begin
      priority if ((key == SC_LSHIFT) || (key == SC_RSHIFT)) begin
        shift_down_next = !released;
      end else if (key == SC_CTRL) begin
        ctrl_down_next = !released;
      end else if (key == SC_ALT) begin
        alt_down_next = !released;
      end else if (is_lock_press && (key == SC_CAPS)) begin
        caps_on_next = !caps_on;
      end else if (is_lock_press && (key == SC_NUM)) begin
        num_on_next = !num_on;
      end else if (is_lock_press) begin
        scroll_on_next = !scroll_on;
      end else begin
        shift_down_next = shift_down;
      end
    end

    ring_cmd.push  = is_other && !released && (key_char != '0);
    ring_cmd.pop   = (opcode == OP_POP);
    ring_cmd.clear = (opcode == OP_CLEAR);
    ring_cmd.wdata = key_char;

    key_out.event_valid     = is_other && event_enable;
    key_out.event_ascii     = (key_out.event_valid && !released) ? key_char : '0;
    key_out.event_scancode  = key_out.event_valid ? scan_byte : '0;
    key_out.event_pressed   = key_out.event_valid && !released;
    key_out.event_modifiers = key_out.event_valid ? mods_before : '0;
    key_out.led_write       = is_scan && is_lock_press;
    key_out.led_bits        = key_out.led_write ?
                              {caps_on_next, num_on_next, scroll_on_next} : '0;
    key_out.modifiers_now   = {alt_down_next, ctrl_down_next, shift_down_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_down <= 1'b0;
      ctrl_down  <= 1'b0;
      alt_down   <= 1'b0;
      caps_on    <= 1'b0;
      num_on     <= 1'b0;
      scroll_on  <= 1'b0;
    end else if (fire) begin
      shift_down <= shift_down_next;
      ctrl_down  <= ctrl_down_next;
      alt_down   <= alt_down_next;
      caps_on    <= caps_on_next;
      num_on     <= num_on_next;
      scroll_on  <= scroll_on_next;
    end
  end

  // A lock press flips exactly one lock bit.
  assert property (@(posedge clk) disable iff (rst)
    (fire && key_out.led_write) |=>
      $countones({caps_on ^ $past(caps_on), num_on ^ $past(num_on),
                  scroll_on ^ $past(scroll_on)}) == 1)
    else $error("lock press did not toggle exactly one lock");

endmodule

FILE: rtl/scat_ring.sv
// Character ring of the scancode translator: memory, positions and a prefetched head.
// Depends on scat_pkg.
module scat_ring #(
  parameter int RING_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  scat_pkg::ring_cmd_t  cmd,
  output scat_pkg::ring_stat_t stat
);
  import scat_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(RING_DEPTH - 1);

  logic [6:0]    mem [RING_DEPTH];
  logic [PW-1:0] write_pos, read_pos;
  logic [PW-1:0] write_pos_next, read_pos_next;
  logic [PW-1:0] write_inc, read_inc;
  logic [PW-1:0] head_addr;
  logic [6:0]    head;
  logic          empty, full;
  logic          push_ok, pop_ok;

  always_comb begin
    write_inc = (write_pos == LAST_POS) ? '0 : write_pos + 1'b1;
    read_inc  = (read_pos == LAST_POS) ? '0 : read_pos + 1'b1;
    empty     = (write_pos == read_pos);
    full      = (write_inc == read_pos);
    push_ok   = cmd.push && !full;
    pop_ok    = cmd.pop && !empty;

    write_pos_next = write_pos;
    read_pos_next  = read_pos;
    if (cmd.clear) begin
      write_pos_next = '0;
      read_pos_next  = '0;
    end else begin
      if (push_ok) begin
        write_pos_next = write_inc;
      end
      if (pop_ok) begin
        read_pos_next = read_inc;
      end
    end

    head_addr = fire ? read_pos_next : read_pos;

    stat.read_char    = pop_ok ? head : '0;
    stat.char_dropped = cmd.push && full;
    stat.has_input    = (write_pos_next != read_pos_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      read_pos  <= '0;
    end else if (fire) begin
      write_pos <= write_pos_next;
      read_pos  <= read_pos_next;
    end
  end

  // The head always holds the entry at the read position, including one written this cycle.
  always_ff @(posedge clk) begin
    if (fire && push_ok) begin
      mem[write_pos] <= cmd.wdata;
    end
    if (fire && push_ok && (write_pos == head_addr)) begin
      head <= cmd.wdata;
    end else begin
      head <= mem[head_addr];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (fire && cmd.clear) |=> (write_pos == '0) && (read_pos == '0))
    else $error("clear did not reset the ring positions");

  assert property (@(posedge clk) disable iff (rst)
    (fire && push_ok) |=> (write_pos != read_pos))
    else $error("ring empty after a stored character");

endmodule

FILE: rtl/scancode_to_ascii_translator.sv
// Top level of the scancode-set-1 to ASCII translator.
// Depends on scat_pkg, scat_if, scat_keystate and scat_ring.
//
// The cmd channel takes one beat per command: opcode 0 delivers a set-1
// scancode byte, opcode 1 pops a character from the ring and opcode 2 clears
// the ring. Every command beat yields exactly one beat on the res channel,
// in order. The cfg channel writes the event enable bit; it is always ready
// and should only be written while no command is in flight.
// A command beat is registered in the input register, then translated against
// the modifier, lock and ring state and written into the result register once
// that register is free. One command is accepted every cycle while the receiver
// keeps taking results; the ring read port prefetches the oldest character so
// back-to-back pops proceed.
// When the receiver stalls, the result register holds its beat and the
// input register fills, after which cmd.ready drops until a result leaves.
// Reset clears modifiers, locks, event enable and both ring positions; the
// ring contents are not cleared and are only read after being written.
module scancode_to_ascii_translator #(
  parameter int RING_DEPTH = 256
) (
  input logic       clk,
  input logic       rst,
  scat_cmd_if.sink  cmd,
  scat_cfg_if.sink  cfg,
  scat_res_if.source res
);
  import scat_pkg::*;

  logic       event_enable;
  logic       stage_valid;
  logic [1:0] stage_opcode;
  logic [7:0] stage_byte;
  logic       out_free;
  logic       fire;
  logic       accept;

  key_out_t   key_out;
  ring_cmd_t  ring_cmd;
  ring_stat_t ring_stat;

  key_out_t   key_res;
  ring_stat_t ring_res;

  assign out_free  = !res.valid || res.ready;
  assign fire      = stage_valid && out_free;
  assign cmd.ready = !stage_valid || out_free;
  assign accept    = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_enable <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      event_enable <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_opcode <= cmd.opcode;
      stage_byte   <= cmd.scan_byte;
    end
  end

  scat_keystate u_keystate (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .opcode       (stage_opcode),
    .scan_byte    (stage_byte),
    .event_enable (event_enable),
    .key_out      (key_out),
    .ring_cmd     (ring_cmd)
  );

  scat_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cmd  (ring_cmd),
    .stat (ring_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (fire) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      key_res  <= key_out;
      ring_res <= ring_stat;
    end
  end

  assign res.event_valid     = key_res.event_valid;
  assign res.event_ascii     = key_res.event_ascii;
  assign res.event_scancode  = key_res.event_scancode;
  assign res.event_pressed   = key_res.event_pressed;
  assign res.event_modifiers = key_res.event_modifiers;
  assign res.led_write       = key_res.led_write;
  assign res.led_bits        = key_res.led_bits;
  assign res.read_char       = ring_res.read_char;
  assign res.char_dropped    = ring_res.char_dropped;
  assign res.has_input       = ring_res.has_input;
  assign res.modifiers_now   = key_res.modifiers_now;

  assert property (@(posedge clk) disable iff (rst)
    fire |=> res.valid)
    else $error("translated command produced no result beat");

  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !fire) |=> stage_valid)
    else $error("registered command lost while the result side stalled");

endmodule
